// ===== src/msrt_pkg.sv =====
// Package for the multi-slot repeat ticker: command codes and the
// transaction structs of the command and result channels.
// No dependencies.
package msrt_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_ARM   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         slot_index;
        logic [15:0]        start_delay;
        logic [15:0]        repeat_period;
        logic signed [15:0] repeat_count;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         fired_slot;
        logic signed [15:0] remaining_count;
        logic               retired;
        logic               last;
    } t_result;

endpackage

// ===== src/multi_slot_repeat_ticker_top.sv =====
// Multi-slot repeat ticker: arm and clear transactions complete without raising
// busy; a tick transaction keeps busy high while it walks the slot memory, one
// read-modify-write per cycle. Each fire is held until the next fire is found, then
// registered to the output; the final one, with last set, appears as busy falls.
// Reset clears the active bits; slot memory is not cleared, since only armed slots
// are ever used. Depends on msrt_pkg.
module multi_slot_repeat_ticker_top #(
    parameter int SLOTS       = 16,
    parameter int TICK_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  msrt_pkg::t_cmd   i_cmd,
    output logic             o_strobe,
    output msrt_pkg::t_result o_result
);

    localparam int IW = $clog2(SLOTS);
    localparam int TW = TICK_WIDTH;
    localparam int CW = COUNT_WIDTH;
    localparam int MW = 2 * TW + CW;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam longint CMIN = -CMAX - 64'sd1;

    typedef enum logic {ST_IDLE, ST_WALK} t_state;

    t_state r_state;
    logic [SLOTS-1:0] r_active;
    logic [IW:0] r_rd_cnt;
    logic r_p1;
    logic [IW-1:0] r_p1_idx;
    logic [MW-1:0] r_rdata;
    logic r_pend_v;
    msrt_pkg::t_result r_pend;
    logic r_out_v;
    msrt_pkg::t_result r_out;

    logic [MW-1:0] mem [SLOTS];

    logic w_acc;
    logic w_in_range;
    logic [IW-1:0] w_arm_addr;
    logic w_issue;
    logic w_proc;
    logic w_done;
    logic [TW-1:0] w_ticks;
    logic [TW-1:0] w_period;
    logic signed [CW-1:0] w_count;
    logic [TW-1:0] w_tdec;
    logic w_fire;
    logic signed [CW-1:0] w_cdec;
    logic w_retire;
    logic [TW-1:0] w_new_ticks;
    logic signed [63:0] w_cnt_in;
    logic signed [CW-1:0] w_cnt_sat;
    logic w_we;
    logic [IW-1:0] w_waddr;
    logic [MW-1:0] w_wdata;
    msrt_pkg::t_result w_res;
    msrt_pkg::t_result w_pend_last;

    assign busy       = (r_state != ST_IDLE);
    assign w_acc      = start && !busy;
    assign w_in_range = (32'(i_cmd.slot_index) < SLOTS);
    assign w_arm_addr = IW'(i_cmd.slot_index);
    assign w_issue    = (r_state == ST_WALK) && (r_rd_cnt < (IW + 1)'(SLOTS));
    assign w_proc     = r_p1 && r_active[r_p1_idx];
    assign w_done     = !w_issue && !r_p1;

    always_comb begin
        w_cnt_in = 64'(i_cmd.repeat_count);
        if (w_cnt_in > CMAX) begin
            w_cnt_sat = CW'(CMAX);
        end else if (w_cnt_in < CMIN) begin
            w_cnt_sat = CW'(CMIN);
        end else begin
            w_cnt_sat = CW'(w_cnt_in);
        end
    end

    always_comb begin
        w_ticks  = r_rdata[MW-1 -: TW];
        w_period = r_rdata[TW+CW-1 -: TW];
        w_count  = r_rdata[CW-1:0];
        w_tdec   = (w_ticks != '0) ? w_ticks - TW'(1) : w_ticks;
        w_fire   = (w_tdec == '0);
        if (!w_count[CW-1] && (w_count != '0)) begin
            w_cdec = w_count - CW'(1);
        end else begin
            w_cdec = w_count;
        end
        w_retire = w_fire && (w_cdec == '0);
        if (!w_fire) begin
            w_new_ticks = w_tdec;
        end else if (w_retire) begin
            w_new_ticks = '0;
        end else begin
            w_new_ticks = w_period;
        end
        w_res.fired_slot      = 4'(r_p1_idx);
        w_res.remaining_count = 16'(w_cdec);
        w_res.retired         = w_retire;
        w_res.last            = 1'b0;
    end

    always_comb begin
        w_pend_last      = r_pend;
        w_pend_last.last = 1'b1;
    end

    always_comb begin
        if (w_proc) begin
            w_we    = 1'b1;
            w_waddr = r_p1_idx;
            w_wdata = {w_new_ticks, w_period, (w_fire ? w_cdec : w_count)};
        end else begin
            w_we    = w_acc && (i_cmd.cmd == msrt_pkg::CMD_ARM) && w_in_range;
            w_waddr = w_arm_addr;
            w_wdata = {TW'(i_cmd.start_delay), TW'(i_cmd.repeat_period), w_cnt_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_issue) begin
            r_rdata <= mem[r_rd_cnt[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_rd_cnt <= '0;
            r_p1     <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_out_v <= 1'b0;
                    if (start) begin
                        case (i_cmd.cmd)
                            msrt_pkg::CMD_TICK: begin
                                r_state  <= ST_WALK;
                                r_rd_cnt <= '0;
                                r_pend_v <= 1'b0;
                            end
                            msrt_pkg::CMD_ARM: begin
                                if (w_in_range) begin
                                    r_active[w_arm_addr] <= 1'b1;
                                end
                            end
                            msrt_pkg::CMD_CLEAR: begin
                                if (w_in_range) begin
                                    r_active[w_arm_addr] <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_WALK: begin
                    r_p1     <= w_issue;
                    r_p1_idx <= r_rd_cnt[IW-1:0];
                    r_out_v  <= r_pend_v && ((w_proc && w_fire) || w_done);
                    if (w_issue) begin
                        r_rd_cnt <= r_rd_cnt + (IW + 1)'(1);
                    end
                    if (w_proc && w_fire) begin
                        if (w_retire) begin
                            r_active[r_p1_idx] <= 1'b0;
                        end
                        if (r_pend_v) begin
                            r_out <= r_pend;
                        end
                        r_pend   <= w_res;
                        r_pend_v <= 1'b1;
                    end
                    if (w_done) begin
                        if (r_pend_v) begin
                            r_out <= w_pend_last;
                        end
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_out_v <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_out_v;
    assign o_result = r_out;

    a_strobe_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a tick in progress");

    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.last == !busy))
        else $error("last flag does not match the end of the tick");

    a_retire_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.retired) |-> (o_result.remaining_count == '0))
        else $error("retired slot reports a nonzero count");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_cnt <= (IW + 1)'(SLOTS))
        else $error("read counter ran past the slot table");

endmodule

// ===== tb/msrt_fire_checker.sv =====
// Fire checker for the multi-slot repeat ticker: keeps its own slot table, works out
// the fires of every accepted tick transaction and compares them with the result port.
// Depends on msrt_pkg.
module msrt_fire_checker #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  msrt_pkg::t_cmd    i_cmd,
    input  logic              i_strobe,
    input  msrt_pkg::t_result i_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    logic               slot_armed     [SLOTS];
    logic signed [15:0] slot_fires_left[SLOTS];
    logic        [15:0] slot_reload    [SLOTS];
    logic        [15:0] slot_countdown [SLOTS];

    msrt_pkg::t_result pending_fires[$];
    int      fails   = 0;
    int      checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    task automatic advance_slots(input msrt_pkg::t_cmd c);
        msrt_pkg::t_result fire;
        msrt_pkg::t_result held;
        bit      have_held;
        have_held = 1'b0;
        case (c.cmd)
            msrt_pkg::CMD_ARM: begin
                slot_armed[c.slot_index]      = 1'b1;
                slot_countdown[c.slot_index]  = c.start_delay;
                slot_reload[c.slot_index]     = c.repeat_period;
                slot_fires_left[c.slot_index] = c.repeat_count;
            end
            msrt_pkg::CMD_CLEAR: begin
                slot_armed[c.slot_index] = 1'b0;
            end
            msrt_pkg::CMD_TICK: begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_armed[s]) begin
                        if (slot_countdown[s] != 16'd0) begin
                            slot_countdown[s] = slot_countdown[s] - 16'd1;
                        end
                        if (slot_countdown[s] == 16'd0) begin
                            if (slot_fires_left[s] > 0) begin
                                slot_fires_left[s] = slot_fires_left[s] - 16'sd1;
                            end
                            fire.fired_slot      = 4'(s);
                            fire.remaining_count = slot_fires_left[s];
                            fire.retired         = (slot_fires_left[s] == 16'sd0);
                            fire.last            = 1'b0;
                            if (fire.retired) begin
                                slot_armed[s] = 1'b0;
                            end else begin
                                slot_countdown[s] = slot_reload[s];
                            end
                            if (have_held) begin
                                pending_fires.push_back(held);
                            end
                            held      = fire;
                            have_held = 1'b1;
                        end
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    pending_fires.push_back(held);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_fire(input msrt_pkg::t_result got);
        msrt_pkg::t_result want;
        if (pending_fires.size() == 0) begin
            $error("unexpected fire result for slot %0d", got.fired_slot);
            fails++;
        end else begin
            want = pending_fires.pop_front();
            checked++;
            if (got.fired_slot !== want.fired_slot) begin
                $error("fired_slot: expected %0d, actual %0d", want.fired_slot, got.fired_slot);
                fails++;
            end
            if (got.remaining_count !== want.remaining_count) begin
                $error("remaining_count: expected %0d, actual %0d",
                       want.remaining_count, got.remaining_count);
                fails++;
            end
            if (got.retired !== want.retired) begin
                $error("retired: expected %0d, actual %0d", want.retired, got.retired);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_armed[s]      = 1'b0;
                slot_fires_left[s] = '0;
                slot_reload[s]     = '0;
                slot_countdown[s]  = '0;
            end
            pending_fires.delete();
        end else begin
            if (i_strobe === 1'b1) begin
                compare_fire(i_result);
            end
            if (i_start && !i_busy) begin
                advance_slots(i_cmd);
            end
        end
        o_pending <= pending_fires.size();
    end

endmodule

// ===== tb/multi_slot_repeat_ticker_top_test.sv =====
// Testbench top for the multi-slot repeat ticker: drives directed and random arm, clear,
// tick and unused-code transactions, mostly with random gaps, and reports the verdict.
// Depends on msrt_pkg, multi_slot_repeat_ticker_top and msrt_fire_checker.
module multi_slot_repeat_ticker_top_test;

    localparam int         SLOTS        = 16;
    localparam int         SETTLE_TICKS = SLOTS + 8;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic    clk     = 1'b0;
    logic    rst_n   = 1'b0;
    logic    start   = 1'b0;
    msrt_pkg::t_cmd    cmd_bus = '0;
    logic    busy;
    logic    strobe;
    msrt_pkg::t_result result;

    int fail_count;
    int pending;
    int checked;
    int sent       = 0;
    int ticks_sent = 0;
    bit idle_on    = 1'b1;

    always #1 clk = ~clk;

    multi_slot_repeat_ticker_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_bus),
        .o_strobe(strobe),
        .o_result(result)
    );

    msrt_fire_checker #(.SLOTS(SLOTS)) fire_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (cmd_bus),
        .i_strobe    (strobe),
        .i_result    (result),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        #200000;
        $display("[multi_slot_repeat_ticker_top] ERROR");
        $finish;
    end

    function automatic msrt_pkg::t_cmd make_cmd(input logic [1:0] op, input int slot,
                                      input logic [15:0] delay, input logic [15:0] period,
                                      input logic signed [15:0] count);
        msrt_pkg::t_cmd c;
        c.cmd           = op;
        c.slot_index    = 4'(slot);
        c.start_delay   = delay;
        c.repeat_period = period;
        c.repeat_count  = count;
        return c;
    endfunction

    function automatic msrt_pkg::t_cmd random_arm();
        logic        [15:0] delay;
        logic        [15:0] period;
        logic signed [15:0] count;
        int                 pick;
        delay  = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        period = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        pick   = $urandom_range(0, 9);
        if (pick < 4) begin
            count = 16'($urandom_range(0, 4));
        end else if (pick < 7) begin
            count = 16'(0 - $urandom_range(1, 3));
        end else begin
            count = 16'($urandom);
        end
        return make_cmd(msrt_pkg::CMD_ARM, $urandom_range(0, SLOTS - 1), delay, period, count);
    endfunction

    task automatic issue(input msrt_pkg::t_cmd c);
        if (idle_on && $urandom_range(0, 99) < 34) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 34);
        end
        start   <= 1'b1;
        cmd_bus <= c;
        do @(posedge clk); while (busy);
        sent++;
        if (c.cmd == msrt_pkg::CMD_TICK) begin
            ticks_sent++;
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic random_item();
        int   pick;
        msrt_pkg::t_cmd c;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            c = make_cmd(msrt_pkg::CMD_TICK, $urandom_range(0, SLOTS - 1), 16'($urandom),
                         16'($urandom), 16'($urandom));
        end else if (pick < 75) begin
            c = random_arm();
        end else if (pick < 93) begin
            c = make_cmd(msrt_pkg::CMD_CLEAR, $urandom_range(0, SLOTS - 1), 16'($urandom),
                         16'($urandom), 16'($urandom));
        end else begin
            c = make_cmd(CMD_UNUSED, $urandom_range(0, SLOTS - 1), 16'($urandom),
                         16'($urandom), 16'($urandom));
        end
        issue(c);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(make_cmd(msrt_pkg::CMD_TICK, 0, 16'd0, 16'd0, 16'sd0));
        issue(make_cmd(msrt_pkg::CMD_ARM, 0, 16'd0, 16'd0, 16'sd0));
        issue(make_cmd(msrt_pkg::CMD_ARM, 1, 16'd0, 16'd0, -16'sd1));
        issue(make_cmd(msrt_pkg::CMD_ARM, 15, 16'd1, 16'd2, 16'sd2));
        issue(make_cmd(msrt_pkg::CMD_ARM, 7, 16'd2, 16'd0, 16'sd3));
        issue(make_cmd(msrt_pkg::CMD_ARM, 3, 16'hFFFF, 16'hFFFF, 16'sh7FFF));
        issue(make_cmd(msrt_pkg::CMD_ARM, 4, 16'd3, 16'd1, 16'sh8000));
        issue(make_cmd(CMD_UNUSED, 15, 16'hFFFF, 16'hFFFF, 16'shFFFF));
        repeat (4) issue(make_cmd(msrt_pkg::CMD_TICK, 15, 16'hFFFF, 16'hFFFF, 16'shFFFF));
        issue(make_cmd(msrt_pkg::CMD_CLEAR, 1, 16'd0, 16'd0, 16'sd0));
        issue(make_cmd(msrt_pkg::CMD_CLEAR, 9, 16'd0, 16'd0, 16'sd0));
        issue(make_cmd(msrt_pkg::CMD_CLEAR, 3, 16'd0, 16'd0, 16'sd0));
        repeat (2) issue(make_cmd(msrt_pkg::CMD_TICK, 0, 16'd0, 16'd0, 16'sd0));
        issue(make_cmd(msrt_pkg::CMD_ARM, 3, 16'd0, 16'h8000, 16'sd1));
        repeat (2) issue(make_cmd(msrt_pkg::CMD_TICK, 0, 16'd0, 16'd0, 16'sd0));
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            idle_on = (phase != 1);
            if (phase == 2) begin
                for (int s = 0; s < SLOTS; s++) begin
                    issue(make_cmd(msrt_pkg::CMD_ARM, s, 16'd1, 16'd1, -16'sd1));
                end
                repeat (2) issue(make_cmd(msrt_pkg::CMD_TICK, 0, 16'd0, 16'd0, 16'sd0));
            end
            repeat (36) random_item();
            wait_idle();
        end

        $display("Run covered %0d transactions, %0d of them ticks; %0d fire results checked.",
                 sent, ticks_sent, checked);
        if (fail_count == 0) begin
            $display("[multi_slot_repeat_ticker_top] OK");
        end else begin
            $display("[multi_slot_repeat_ticker_top] ERROR");
        end
        $finish;
    end

endmodule
